// File: rtl/chv_pkg.sv
package chv_pkg;

   // Container layout.
   localparam int unsigned HDR_LEN        = 28;
   localparam int unsigned PAYLOAD_CRC_AT = 20;
   localparam int unsigned HEADER_CRC_AT  = 24;
   localparam int unsigned TYPES_VERSION_MIN = 4;

   localparam int unsigned DEFAULT_COUNT_BITS = 32;

   localparam logic [31:0] CRC_POLY = 32'hEDB8_8320;
   localparam logic [31:0] CRC_INIT = 32'hFFFF_FFFF;

   // Configuration register indexes and reset values.
   localparam int unsigned CSR_INDEX_BITS = 2;
   localparam int unsigned CSR_DATA_BITS  = 32;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_MAGIC_WORD        = 2'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_CONTAINER_VERSION = 2'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_MIN_CODE_VERSION  = 2'd2;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_MAX_CODE_VERSION  = 2'd3;

   localparam logic [31:0] MAGIC_WORD_RESET        = 32'h314C_5357;
   localparam logic [15:0] CONTAINER_VERSION_RESET = 16'd1;
   localparam logic [15:0] MIN_CODE_VERSION_RESET  = 16'd3;
   localparam logic [15:0] MAX_CODE_VERSION_RESET  = 16'd14;

   // Result status codes.
   localparam logic [3:0] STATUS_OK            = 4'd0;
   localparam logic [3:0] STATUS_TRUNCATED     = 4'd1;
   localparam logic [3:0] STATUS_MAGIC         = 4'd2;
   localparam logic [3:0] STATUS_VERSION       = 4'd3;
   localparam logic [3:0] STATUS_RESERVED      = 4'd4;
   localparam logic [3:0] STATUS_CODE_VERSION  = 4'd5;
   localparam logic [3:0] STATUS_HEADER_CRC    = 4'd6;
   localparam logic [3:0] STATUS_PAYLOAD_CRC   = 4'd7;
   localparam logic [3:0] STATUS_PAYLOAD_SHORT = 4'd8;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       last_byte;
   } req_type;

   typedef struct packed {
      logic [7:0] payload_byte;
      logic       payload_valid;
      logic       is_last;
      logic [3:0] status;
   } rsp_type;

   // Reflected CRC-32, one byte per call.
   function automatic logic [31:0] crc32_byte(input logic [31:0] crc, input logic [7:0] b);
      logic [31:0] c;
      c = crc ^ {24'd0, b};
      for (int i = 0; i < 8; i++) begin
         c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
      end
      return c;
   endfunction

endpackage

// File: rtl/container_header_validator.sv
// Checks a container that arrives one byte per transfer, last_byte set on its final
// byte. The first 28 bytes are a little-endian header (magic, container version,
// reserved word, code version, payload CRC-32 and header CRC-32); later bytes are
// payload and each one is forwarded as its own result. Header bytes that are not
// final give no result. The final byte always gives a result whose status is the
// first failed check, and the block then starts fresh for the next container. Every
// byte passes the input register and, for a result, the result register; a byte is
// taken every cycle unless the result register is full and stalled. The CRC-32 update
// ahead of that register sets the clock. The byte counter saturates at COUNT_BITS bits.
module container_header_validator #(
   parameter int unsigned COUNT_BITS = chv_pkg::DEFAULT_COUNT_BITS
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  chv_pkg::req_type                     req_data,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output chv_pkg::rsp_type                     rsp_data,
   input  logic                                 csr_write_en,
   input  logic [chv_pkg::CSR_INDEX_BITS-1:0]   csr_index,
   input  logic [chv_pkg::CSR_DATA_BITS-1:0]    csr_data
);

   // Configuration.
   logic [31:0] magic_word_ff;
   logic [15:0] container_version_ff;
   logic [15:0] min_code_version_ff;
   logic [15:0] max_code_version_ff;

   // Input register.
   logic             in_valid_ff;
   chv_pkg::req_type in_data_ff;

   // Per-container state.
   logic [COUNT_BITS-1:0] byte_count_ff, byte_count_in;
   logic [31:0] magic_seen_ff, magic_seen_in;
   logic [15:0] format_version_ff, format_version_in;
   logic [15:0] reserved_word_ff, reserved_word_in;
   logic [15:0] code_version_ff, code_version_in;
   logic [31:0] stored_payload_crc_ff, stored_payload_crc_in;
   logic [31:0] stored_header_crc_ff, stored_header_crc_in;
   logic [31:0] header_crc_run_ff, header_crc_run_in;
   logic [31:0] payload_crc_run_ff, payload_crc_run_in;

   // Result register.
   logic             out_valid_ff;
   chv_pkg::rsp_type out_data_ff;

   logic [7:0]  cur_byte;
   logic        cur_last;
   logic        is_payload;
   logic [4:0]  hdr_off;
   logic        needs_out;
   logic        out_free;
   logic        advance;
   logic        truncated;
   logic [3:0]  check_status;
   chv_pkg::rsp_type result;

   assign cur_byte   = in_data_ff.data_byte;
   assign cur_last   = in_data_ff.last_byte;
   assign is_payload = byte_count_ff >= COUNT_BITS'(chv_pkg::HDR_LEN);
   assign hdr_off    = byte_count_ff[4:0];
   assign needs_out  = is_payload || cur_last;
   assign out_free   = !out_valid_ff || !rsp_stall;
   assign advance    = in_valid_ff && (!needs_out || out_free);
   assign req_stall  = in_valid_ff && !advance;

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_data_ff;

   assign byte_count_in = (&byte_count_ff) ? byte_count_ff : byte_count_ff + 1'b1;

   // Header field capture and running CRCs, including the byte now in hand.
   always_comb begin
      magic_seen_in         = magic_seen_ff;
      format_version_in     = format_version_ff;
      reserved_word_in      = reserved_word_ff;
      code_version_in       = code_version_ff;
      stored_payload_crc_in = stored_payload_crc_ff;
      stored_header_crc_in  = stored_header_crc_ff;
      header_crc_run_in     = header_crc_run_ff;
      payload_crc_run_in    = payload_crc_run_ff;
      if (is_payload) begin
         payload_crc_run_in = chv_pkg::crc32_byte(payload_crc_run_ff, cur_byte);
      end else begin
         case (hdr_off) inside
            [5'd0:5'd3]:   magic_seen_in[hdr_off[1:0]*8 +: 8] = cur_byte;
            [5'd4:5'd5]:   format_version_in[hdr_off[0]*8 +: 8] = cur_byte;
            [5'd8:5'd9]:   reserved_word_in[hdr_off[0]*8 +: 8] = cur_byte;
            [5'd10:5'd11]: code_version_in[hdr_off[0]*8 +: 8] = cur_byte;
            [5'd20:5'd23]: stored_payload_crc_in[hdr_off[1:0]*8 +: 8] = cur_byte;
            [5'd24:5'd27]: stored_header_crc_in[hdr_off[1:0]*8 +: 8] = cur_byte;
            default: ;
         endcase
         // The header CRC field itself is hashed as zeros.
         header_crc_run_in = chv_pkg::crc32_byte(header_crc_run_ff,
            (hdr_off >= 5'(chv_pkg::HEADER_CRC_AT)) ? 8'd0 : cur_byte);
      end
   end

   assign truncated = byte_count_ff < COUNT_BITS'(chv_pkg::HDR_LEN - 1);

   always_comb begin
      if (magic_seen_in != magic_word_ff) begin
         check_status = chv_pkg::STATUS_MAGIC;
      end else if (format_version_in != container_version_ff) begin
         check_status = chv_pkg::STATUS_VERSION;
      end else if (reserved_word_in != 16'd0) begin
         check_status = chv_pkg::STATUS_RESERVED;
      end else if (code_version_in < min_code_version_ff ||
                   code_version_in > max_code_version_ff) begin
         check_status = chv_pkg::STATUS_CODE_VERSION;
      end else if (~header_crc_run_in != stored_header_crc_in) begin
         check_status = chv_pkg::STATUS_HEADER_CRC;
      end else if (~payload_crc_run_in != stored_payload_crc_in) begin
         check_status = chv_pkg::STATUS_PAYLOAD_CRC;
      end else if (byte_count_ff == COUNT_BITS'(chv_pkg::HDR_LEN - 1)) begin
         // Empty payload.
         check_status = chv_pkg::STATUS_PAYLOAD_SHORT;
      end else if (byte_count_ff == COUNT_BITS'(chv_pkg::HDR_LEN) &&
                   cur_byte >= 8'(chv_pkg::TYPES_VERSION_MIN)) begin
         // A one-byte payload whose type byte asks for more.
         check_status = chv_pkg::STATUS_PAYLOAD_SHORT;
      end else begin
         check_status = chv_pkg::STATUS_OK;
      end
   end

   always_comb begin
      result.payload_byte  = is_payload ? cur_byte : 8'd0;
      result.payload_valid = is_payload;
      result.is_last       = cur_last;
      if (!cur_last) begin
         result.status = chv_pkg::STATUS_OK;
      end else if (truncated) begin
         result.status = chv_pkg::STATUS_TRUNCATED;
      end else begin
         result.status = check_status;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         magic_word_ff        <= chv_pkg::MAGIC_WORD_RESET;
         container_version_ff <= chv_pkg::CONTAINER_VERSION_RESET;
         min_code_version_ff  <= chv_pkg::MIN_CODE_VERSION_RESET;
         max_code_version_ff  <= chv_pkg::MAX_CODE_VERSION_RESET;
      end else if (csr_write_en) begin
         case (csr_index)
            chv_pkg::CSR_MAGIC_WORD:        magic_word_ff        <= csr_data;
            chv_pkg::CSR_CONTAINER_VERSION: container_version_ff <= csr_data[15:0];
            chv_pkg::CSR_MIN_CODE_VERSION:  min_code_version_ff  <= csr_data[15:0];
            chv_pkg::CSR_MAX_CODE_VERSION:  max_code_version_ff  <= csr_data[15:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (!req_stall) begin
         in_valid_ff <= req_valid;
      end
      if (req_valid && !req_stall) begin
         in_data_ff <= req_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         byte_count_ff      <= '0;
         header_crc_run_ff  <= chv_pkg::CRC_INIT;
         payload_crc_run_ff <= chv_pkg::CRC_INIT;
      end else if (advance) begin
         if (cur_last) begin
            byte_count_ff      <= '0;
            header_crc_run_ff  <= chv_pkg::CRC_INIT;
            payload_crc_run_ff <= chv_pkg::CRC_INIT;
         end else begin
            byte_count_ff      <= byte_count_in;
            header_crc_run_ff  <= header_crc_run_in;
            payload_crc_run_ff <= payload_crc_run_in;
         end
      end
      // Every header field is rewritten before any check reads it.
      if (advance) begin
         magic_seen_ff         <= magic_seen_in;
         format_version_ff     <= format_version_in;
         reserved_word_ff      <= reserved_word_in;
         code_version_ff       <= code_version_in;
         stored_payload_crc_ff <= stored_payload_crc_in;
         stored_header_crc_ff  <= stored_header_crc_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance && needs_out) begin
         out_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         out_valid_ff <= 1'b0;
      end
      if (advance && needs_out) begin
         out_data_ff <= result;
      end
   end

endmodule

// File: tb/sv/chv_tb_pkg.sv
`timescale 1ns / 1ps
package chv_tb_pkg;
   import chv_pkg::*;

   // Reflected CRC-32 advanced by one byte, bit-serial form.
   function automatic logic [31:0] crc32_step(input logic [31:0] crc, input logic [7:0] b);
      logic [31:0] acc;
      logic        feedback;
      acc = crc;
      for (int k = 0; k < 8; k++) begin
         feedback = acc[0] ^ b[k];
         acc = acc >> 1;
         if (feedback) begin
            acc = acc ^ CRC_POLY;
         end
      end
      return acc;
   endfunction

   class container_scoreboard;
      logic [31:0] magic_word;
      logic [15:0] container_version;
      logic [15:0] min_code;
      logic [15:0] max_code;

      logic [31:0] byte_count;
      logic [31:0] magic_seen;
      logic [15:0] format_version;
      logic [15:0] reserved_word;
      logic [15:0] code_version;
      logic [31:0] payload_crc_field;
      logic [31:0] header_crc_field;
      logic [31:0] header_crc;
      logic [31:0] payload_crc;
      logic [7:0]  first_payload;

      rsp_type     expected_results[$];
      int          failures;
      int          results_seen;

      function new();
         magic_word = MAGIC_WORD_RESET;
         container_version = CONTAINER_VERSION_RESET;
         min_code = MIN_CODE_VERSION_RESET;
         max_code = MAX_CODE_VERSION_RESET;
         failures = 0;
         results_seen = 0;
         clear_container();
      endfunction

      function void clear_container();
         byte_count = '0;
         magic_seen = '0;
         format_version = '0;
         reserved_word = '0;
         code_version = '0;
         payload_crc_field = '0;
         header_crc_field = '0;
         header_crc = CRC_INIT;
         payload_crc = CRC_INIT;
         first_payload = '0;
      endfunction

      function void set_register(input logic [CSR_INDEX_BITS-1:0] index,
                                 input logic [CSR_DATA_BITS-1:0] value);
         case (index)
            CSR_MAGIC_WORD:        magic_word = value;
            CSR_CONTAINER_VERSION: container_version = value[15:0];
            CSR_MIN_CODE_VERSION:  min_code = value[15:0];
            CSR_MAX_CODE_VERSION:  max_code = value[15:0];
            default: ;
         endcase
      endfunction

      function logic [3:0] first_failed_check(input logic [31:0] payload_len);
         if (magic_seen != magic_word) return STATUS_MAGIC;
         if (format_version != container_version) return STATUS_VERSION;
         if (reserved_word != 16'h0) return STATUS_RESERVED;
         if (code_version < min_code || code_version > max_code) return STATUS_CODE_VERSION;
         if (~header_crc != header_crc_field) return STATUS_HEADER_CRC;
         if (~payload_crc != payload_crc_field) return STATUS_PAYLOAD_CRC;
         if (payload_len == 0) return STATUS_PAYLOAD_SHORT;
         // A newer payload format needs at least two bytes.
         if (32'(first_payload) >= TYPES_VERSION_MIN && payload_len < 2)
            return STATUS_PAYLOAD_SHORT;
         return STATUS_OK;
      endfunction

      function void note_byte(input req_type item);
         logic [31:0] off;
         logic [7:0]  b;
         logic [3:0]  status;
         logic        in_payload;
         rsp_type     r;
         int          o;
         b = item.data_byte;
         off = byte_count;
         o = int'(off);
         status = STATUS_OK;
         in_payload = (off >= HDR_LEN);
         if (byte_count != '1) begin
            byte_count = byte_count + 1;
         end
         if (!in_payload) begin
            if (o < 4) begin
               magic_seen |= 32'(b) << (8 * o);
            end else if (o < 6) begin
               format_version |= 16'(b) << (8 * (o - 4));
            end else if (o >= 8 && o < 10) begin
               reserved_word |= 16'(b) << (8 * (o - 8));
            end else if (o >= 10 && o < 12) begin
               code_version |= 16'(b) << (8 * (o - 10));
            end else if (o >= int'(PAYLOAD_CRC_AT) && o < int'(HEADER_CRC_AT)) begin
               payload_crc_field |= 32'(b) << (8 * (o % 4));
            end else if (o >= int'(HEADER_CRC_AT)) begin
               header_crc_field |= 32'(b) << (8 * (o % 4));
            end
            // The stored header CRC itself is covered as zero bytes.
            header_crc = crc32_step(header_crc, (off >= HEADER_CRC_AT) ? 8'h00 : b);
         end else begin
            if (off == HDR_LEN) begin
               first_payload = b;
            end
            payload_crc = crc32_step(payload_crc, b);
         end
         if (!in_payload && !item.last_byte) return;
         if (item.last_byte) begin
            if (off < HDR_LEN - 1) begin
               status = STATUS_TRUNCATED;
            end else begin
               status = first_failed_check(byte_count - HDR_LEN);
            end
         end
         r.payload_byte = in_payload ? b : 8'h00;
         r.payload_valid = in_payload;
         r.is_last = item.last_byte;
         r.status = status;
         expected_results.push_back(r);
         if (item.last_byte) begin
            clear_container();
         end
      endfunction

      function void note_failure(input string msg);
         failures++;
         if (failures <= 10) begin
            $display("%s", msg);
         end
      endfunction

      function void check_result(input rsp_type got);
         rsp_type want;
         results_seen++;
         if (expected_results.size() == 0) begin
            note_failure($sformatf("result %0d arrived with nothing expected: byte %h valid %b last %b status %0d",
                                   results_seen, got.payload_byte, got.payload_valid,
                                   got.is_last, got.status));
            return;
         end
         want = expected_results.pop_front();
         if (got.payload_byte !== want.payload_byte || got.payload_valid !== want.payload_valid ||
             got.is_last !== want.is_last || got.status !== want.status) begin
            note_failure($sformatf("result %0d mismatch: expected byte %h valid %b last %b status %0d, got byte %h valid %b last %b status %0d",
                                   results_seen, want.payload_byte, want.payload_valid,
                                   want.is_last, want.status, got.payload_byte,
                                   got.payload_valid, got.is_last, got.status));
         end
      endfunction

      function int pending();
         return expected_results.size();
      endfunction
   endclass

endpackage

// File: tb/sv/testbench.sv
`timescale 1ns / 1ps
module testbench;
   import chv_pkg::*;
   import chv_tb_pkg::*;

   logic                      clock;
   logic                      reset;
   logic                      req_valid;
   logic                      req_stall;
   req_type                   req_data;
   logic                      rsp_valid;
   logic                      rsp_stall = 1'b0;
   rsp_type                   rsp_data;
   logic                      csr_write_en;
   logic [CSR_INDEX_BITS-1:0] csr_index;
   logic [CSR_DATA_BITS-1:0]  csr_data;

   container_scoreboard scoreboard;
   logic [7:0]  frame[$];
   logic [31:0] cfg_magic;
   logic [15:0] cfg_version;
   logic [15:0] cfg_min_code;
   logic [15:0] cfg_max_code;
   int          burst_left;
   int          bytes_accepted;
   int          stall_mode;
   int          stall_left = 0;

   container_header_validator dut (.*);

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   initial begin
      #2_000_000;
      $display("simulation failed");
      $finish;
   end

   // The result side alternates between free flow, light, medium and heavy stalling.
   always @(posedge clock) begin
      if (stall_left == 0) begin
         stall_mode = $urandom_range(3, 0);
         stall_left = $urandom_range(200, 20);
      end else begin
         stall_left--;
      end
      case (stall_mode)
         0: rsp_stall <= 1'b0;
         1: rsp_stall <= ($urandom_range(3, 0) == 0);
         2: rsp_stall <= ($urandom_range(1, 0) == 0);
         default: rsp_stall <= ($urandom_range(9, 0) < 8);
      endcase
   end

   // Handshake signals are stable from the falling edge to the next rising edge.
   always @(negedge clock) begin
      if (!reset && rsp_valid === 1'b1 && rsp_stall === 1'b0) begin
         scoreboard.check_result(rsp_data);
      end
   end

   task automatic send_byte(input logic [7:0] b, input logic last);
      logic    taken;
      int      gap;
      req_type item;
      if (burst_left == 0) begin
         burst_left = $urandom_range(40, 1);
         gap = ($urandom_range(3, 0) == 0) ? 0 : $urandom_range(8, 1);
         if ($urandom_range(15, 0) == 0) begin
            gap = $urandom_range(40, 10);
         end
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      item.data_byte = b;
      item.last_byte = last;
      req_valid <= 1'b1;
      req_data <= item;
      do begin
         @(negedge clock);
         taken = !req_stall;
         @(posedge clock);
      end while (!taken);
      scoreboard.note_byte(item);
      bytes_accepted++;
      burst_left--;
   endtask

   task automatic send_frame(input int count);
      for (int i = 0; i < count; i++) begin
         send_byte(frame[i], (i == count - 1));
      end
   endtask

   function automatic void make_container(input logic [31:0] magic, input logic [15:0] version,
                                          input logic [15:0] reserved, input logic [15:0] code,
                                          input int plen, input logic [7:0] first_byte);
      logic [31:0] crc;
      frame.delete();
      for (int i = 0; i < 4; i++) frame.push_back(magic[8*i +: 8]);
      frame.push_back(version[7:0]);
      frame.push_back(version[15:8]);
      frame.push_back(8'($urandom));
      frame.push_back(8'($urandom));
      frame.push_back(reserved[7:0]);
      frame.push_back(reserved[15:8]);
      frame.push_back(code[7:0]);
      frame.push_back(code[15:8]);
      for (int i = 0; i < 8; i++) frame.push_back(8'($urandom));
      for (int i = 0; i < 8; i++) frame.push_back(8'h00);
      for (int i = 0; i < plen; i++) frame.push_back((i == 0) ? first_byte : 8'($urandom));
      crc = CRC_INIT;
      for (int i = HDR_LEN; i < frame.size(); i++) crc = crc32_step(crc, frame[i]);
      crc = ~crc;
      for (int i = 0; i < 4; i++) frame[PAYLOAD_CRC_AT + i] = crc[8*i +: 8];
      crc = CRC_INIT;
      for (int i = 0; i < HDR_LEN; i++) begin
         crc = crc32_step(crc, (i >= HEADER_CRC_AT) ? 8'h00 : frame[i]);
      end
      crc = ~crc;
      for (int i = 0; i < 4; i++) frame[HEADER_CRC_AT + i] = crc[8*i +: 8];
   endfunction

   task automatic send_container(input logic [31:0] magic, input logic [15:0] version,
                                 input logic [15:0] reserved, input logic [15:0] code,
                                 input int plen, input logic [7:0] first_byte);
      make_container(magic, version, reserved, code, plen, first_byte);
      send_frame(frame.size());
   endtask

   task automatic wait_idle();
      req_valid <= 1'b0;
      while (scoreboard.pending() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_config(input logic [31:0] magic, input logic [15:0] version,
                               input logic [15:0] min_code, input logic [15:0] max_code);
      csr_write_en <= 1'b1;
      csr_index <= CSR_MAGIC_WORD;
      csr_data <= magic;
      @(posedge clock);
      csr_index <= CSR_CONTAINER_VERSION;
      csr_data <= {16'h0, version};
      @(posedge clock);
      csr_index <= CSR_MIN_CODE_VERSION;
      csr_data <= {16'h0, min_code};
      @(posedge clock);
      csr_index <= CSR_MAX_CODE_VERSION;
      csr_data <= {16'h0, max_code};
      @(posedge clock);
      csr_write_en <= 1'b0;
      scoreboard.set_register(CSR_MAGIC_WORD, magic);
      scoreboard.set_register(CSR_CONTAINER_VERSION, {16'h0, version});
      scoreboard.set_register(CSR_MIN_CODE_VERSION, {16'h0, min_code});
      scoreboard.set_register(CSR_MAX_CODE_VERSION, {16'h0, max_code});
      cfg_magic = magic;
      cfg_version = version;
      cfg_min_code = min_code;
      cfg_max_code = max_code;
   endtask

   // Mostly well-formed containers; the rest carry one defect, are cut short or are noise.
   task automatic random_container();
      logic [31:0] magic;
      logic [15:0] version;
      logic [15:0] reserved;
      logic [15:0] code;
      logic [7:0]  first_byte;
      int          plen;
      int          kind;
      int          count;
      int          n;
      magic = cfg_magic;
      version = cfg_version;
      reserved = 16'h0;
      if (cfg_min_code <= cfg_max_code) begin
         code = 16'($urandom_range(32'(cfg_max_code), 32'(cfg_min_code)));
         if ($urandom_range(5, 0) == 0) code = cfg_min_code;
         if ($urandom_range(5, 0) == 0) code = cfg_max_code;
      end else begin
         code = 16'($urandom);
      end
      case ($urandom_range(9, 0))
         0: plen = 0;
         1, 2: plen = 1;
         3: plen = 2;
         default: plen = $urandom_range(12, 3);
      endcase
      if ($urandom_range(15, 0) == 0) plen = $urandom_range(80, 13);
      first_byte = ($urandom_range(1, 0) == 0) ? 8'($urandom_range(3, 0)) : 8'($urandom);
      kind = $urandom_range(19, 0);
      case (kind)
         0: magic = magic ^ (32'(1) << $urandom_range(31, 0));
         1: version = version ^ (16'(1) << $urandom_range(15, 0));
         2: reserved = 16'($urandom_range(65535, 1));
         3: begin
            if (cfg_min_code > 0) begin
               code = 16'($urandom_range(32'(cfg_min_code) - 1, 0));
            end else if (cfg_max_code < 16'hFFFF) begin
               code = 16'($urandom_range(65535, 32'(cfg_max_code) + 1));
            end
         end
         default: ;
      endcase
      make_container(magic, version, reserved, code, plen, first_byte);
      count = frame.size();
      case (kind)
         4: frame[$urandom_range(27, 0)] ^= 8'(1 << $urandom_range(7, 0));
         5: begin
            if (plen > 0) begin
               frame[$urandom_range(frame.size() - 1, HDR_LEN)] ^= 8'(1 << $urandom_range(7, 0));
            end
         end
         6, 7: count = $urandom_range(frame.size() - 1, 1);
         default: ;
      endcase
      if (kind == 8) begin
         n = $urandom_range(40, 1);
         for (int i = 0; i < n; i++) begin
            send_byte(8'($urandom), (i == n - 1) || ($urandom_range(15, 0) == 0));
         end
      end else begin
         send_frame(count);
      end
   endtask

   initial begin
      int target;
      reset = 1'b1;
      req_valid = 1'b0;
      req_data = '0;
      csr_write_en = 1'b0;
      csr_index = '0;
      csr_data = '0;
      burst_left = 0;
      bytes_accepted = 0;
      cfg_magic = MAGIC_WORD_RESET;
      cfg_version = CONTAINER_VERSION_RESET;
      cfg_min_code = MIN_CODE_VERSION_RESET;
      cfg_max_code = MAX_CODE_VERSION_RESET;
      scoreboard = new();
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // Directed containers under the reset configuration.
      make_container(cfg_magic, cfg_version, 16'h0, cfg_min_code, 0, 8'h00);
      send_frame(1);
      send_frame(HDR_LEN - 1);
      send_frame(HDR_LEN);
      send_container(cfg_magic, cfg_version, 16'h0, cfg_max_code, 1, 8'h03);
      send_container(cfg_magic, cfg_version, 16'h0, cfg_min_code, 1, 8'h04);
      send_container(cfg_magic, cfg_version, 16'h0, 16'd7, 2, 8'hFF);
      send_container(cfg_magic, cfg_version, 16'h0, 16'd7, 3, 8'h00);
      send_container(cfg_magic ^ 32'h8000_0000, cfg_version, 16'h0, 16'd7, 0, 8'h00);
      send_container(cfg_magic, cfg_version ^ 16'h0002, 16'h0, 16'd7, 2, 8'h01);
      send_container(cfg_magic, cfg_version, 16'h8000, 16'd7, 2, 8'h01);
      send_container(cfg_magic, cfg_version, 16'h0, cfg_min_code - 16'd1, 2, 8'h01);
      send_container(cfg_magic, cfg_version, 16'h0, cfg_max_code + 16'd1, 2, 8'h01);
      make_container(cfg_magic, cfg_version, 16'h0, 16'd5, 4, 8'h02);
      frame[HEADER_CRC_AT] ^= 8'h80;
      send_frame(frame.size());
      make_container(cfg_magic, cfg_version, 16'h0, 16'd5, 4, 8'h02);
      frame[HDR_LEN + 3] ^= 8'h01;
      send_frame(frame.size());

      for (int phase = 0; phase < 6; phase++) begin
         if (phase > 0) begin
            wait_idle();
            case (phase)
               1: write_config($urandom, 16'($urandom), 16'($urandom_range(1000, 0)),
                               16'($urandom_range(3000, 1000)));
               2: write_config(32'hFFFF_FFFF, 16'hFFFF, 16'h0000, 16'hFFFF);
               3: write_config(32'h0000_0000, 16'h0000, 16'hFFFF, 16'hFFFF);
               // Inverted code range: nothing passes the code version check.
               4: write_config($urandom, 16'($urandom), 16'h8000, 16'h7FFF);
               default: write_config($urandom, CONTAINER_VERSION_RESET, 16'h0000, 16'h0000);
            endcase
         end
         target = bytes_accepted + 230;
         while (bytes_accepted < target) random_container();
      end

      req_valid <= 1'b0;
      while (scoreboard.pending() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
      if (scoreboard.failures == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule

// File: filelist.f
rtl/chv_pkg.sv
rtl/container_header_validator.sv
tb/sv/chv_tb_pkg.sv
tb/sv/testbench.sv
